// ----- design/jpeg_bit_packer_with_stuffing_core_macros.svh -----
// Assertion macros for the JPEG bit packer with byte stuffing.
// Used by the controller and datapath modules; expects clk and arst_n in scope.
`ifndef JPEG_BIT_PACKER_WITH_STUFFING_CORE_MACROS_SVH
`define JPEG_BIT_PACKER_WITH_STUFFING_CORE_MACROS_SVH

// Check a property on every rising clock edge outside of reset.
`define JBP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition never holds outside of reset.
`define JBP_ASSERT_NEVER(lbl, cond, msg) \
	`JBP_ASSERT(lbl, !(cond), msg)

`endif

// ----- design/jbp_pkg.sv -----
// Shared constants, codes and control structs for the JPEG bit packer.
// Used by jbp_ctrl, jbp_datapath and the top level; no dependencies.
`default_nettype none

package jbp_pkg;

	// Field and storage widths
	localparam int ADDR_W     = 24;
	localparam int MAX_BITS   = 24;
	localparam int CODE_W     = 24;
	localparam int BCNT_W     = 5;
	localparam int MODE_W     = 2;
	localparam int POS_W      = 25;
	localparam int ACC_W      = MAX_BITS + 7;
	localparam int CNT_W      = $clog2(ACC_W + 1);
	localparam int S_TDATA_W  = 32;
	localparam int M_TDATA_W  = 40;

	localparam logic [POS_W-1:0] CAPACITY_RESET = POS_W'(25'h1000000);

	// Item modes
	localparam logic [MODE_W-1:0] MODE_BITS  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FLUSH = 2'd1;
	localparam logic [MODE_W-1:0] MODE_RAW   = 2'd2;

	localparam logic [7:0] BYTE_FF    = 8'hFF;
	localparam logic [7:0] BYTE_STUFF = 8'h00;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic emit_data;
		logic emit_stuff;
		logic emit_raw;
		logic last;
	} jbp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic out_free;
		logic start_raw;
		logic start_bytes;
		logic byte_is_ff;
		logic more_after_data;
		logic more_after_stuff;
	} jbp_status_t;

endpackage

`default_nettype wire

// ----- design/jbp_datapath.sv -----
// Datapath of the JPEG bit packer: accumulator, write position, capacity,
// output register. Depends on jbp_pkg and the assertion macro header.
`default_nettype none
`include "jpeg_bit_packer_with_stuffing_core_macros.svh"

module jbp_datapath (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire logic [jbp_pkg::S_TDATA_W-1:0] in_data,
	input  wire jbp_pkg::jbp_cmd_t           cmd,
	output jbp_pkg::jbp_status_t             st,
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [jbp_pkg::POS_W-1:0]   cfg_data,
	output logic                             m_tvalid,
	input  wire                              m_tready,
	output logic [jbp_pkg::M_TDATA_W-1:0]    m_tdata,
	output logic                             m_tlast
);

	logic [jbp_pkg::ACC_W-1:0]  acc_q;
	logic [jbp_pkg::CNT_W-1:0]  cnt_q;
	logic [7:0]                 raw_q;
	logic [jbp_pkg::POS_W-1:0]  wp_q;
	logic [jbp_pkg::POS_W-1:0]  cap_q;
	logic                       ovf_q;
	logic                       out_valid_q;
	logic [7:0]                 out_byte_q;
	logic [jbp_pkg::ADDR_W-1:0] out_addr_q;
	logic                       out_written_q;
	logic                       out_ovf_q;
	logic                       out_last_q;

	logic [jbp_pkg::MODE_W-1:0] in_mode;
	logic [jbp_pkg::CODE_W-1:0] in_code;
	logic [jbp_pkg::BCNT_W-1:0] in_bcnt;
	logic [jbp_pkg::CNT_W-1:0]  n_bits;
	logic [jbp_pkg::ACC_W-1:0]  mask;
	logic [jbp_pkg::ACC_W-1:0]  new_bits;
	logic [jbp_pkg::ACC_W-1:0]  acc_new;
	logic [jbp_pkg::CNT_W-1:0]  cnt_new;
	logic                       do_append;
	logic [jbp_pkg::CNT_W-1:0]  shamt;
	logic [jbp_pkg::ACC_W-1:0]  shifted;
	logic [7:0]                 data_byte;
	logic [7:0]                 emit_byte;
	logic                       emit_any;
	logic                       full;

	// Unpack the input word
	assign in_mode = in_data[jbp_pkg::MODE_W-1:0];
	assign in_code = in_data[jbp_pkg::MODE_W +: jbp_pkg::CODE_W];
	assign in_bcnt = in_data[jbp_pkg::MODE_W + jbp_pkg::CODE_W +: jbp_pkg::BCNT_W];

	// Pick the bits to append: clamped code bits, or one-fill up to a byte
	always_comb begin
		n_bits    = '0;
		new_bits  = '0;
		do_append = 1'b0;
		case (in_mode)
			jbp_pkg::MODE_BITS: begin
				n_bits = (in_bcnt > jbp_pkg::BCNT_W'(jbp_pkg::MAX_BITS)) ?
					jbp_pkg::CNT_W'(jbp_pkg::MAX_BITS) : jbp_pkg::CNT_W'(in_bcnt);
				new_bits  = jbp_pkg::ACC_W'(in_code);
				do_append = (n_bits != '0);
			end
			jbp_pkg::MODE_FLUSH: begin
				n_bits    = jbp_pkg::CNT_W'(8) - cnt_q;
				new_bits  = '1;
				do_append = (cnt_q != '0);
			end
			default: begin
				n_bits    = '0;
				new_bits  = '0;
				do_append = 1'b0;
			end
		endcase
	end

	assign mask    = ~({jbp_pkg::ACC_W{1'b1}} << n_bits);
	assign acc_new = (acc_q << n_bits) | (new_bits & mask);
	assign cnt_new = cnt_q + n_bits;

	// Take the top pending byte
	assign shamt     = cnt_q - jbp_pkg::CNT_W'(8);
	assign shifted   = acc_q >> shamt;
	assign data_byte = shifted[7:0];

	assign full     = (wp_q >= cap_q);
	assign emit_any = cmd.emit_data | cmd.emit_stuff | cmd.emit_raw;

	always_comb begin
		emit_byte = jbp_pkg::BYTE_STUFF;
		if (cmd.emit_data) begin
			emit_byte = data_byte;
		end else if (cmd.emit_raw) begin
			emit_byte = raw_q;
		end
	end

	// Status to the controller
	assign st.out_free         = !out_valid_q || m_tready;
	assign st.start_raw        = (in_mode == jbp_pkg::MODE_RAW);
	assign st.start_bytes      = do_append && (cnt_new >= jbp_pkg::CNT_W'(8));
	assign st.byte_is_ff       = (data_byte == jbp_pkg::BYTE_FF);
	assign st.more_after_data  = (cnt_q >= jbp_pkg::CNT_W'(16));
	assign st.more_after_stuff = (cnt_q >= jbp_pkg::CNT_W'(8));

	// Hold the capacity register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= jbp_pkg::CAPACITY_RESET;
		end else if (cfg_valid) begin
			cap_q <= cfg_data;
		end
	end

	// Advance the accumulator and pending count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			cnt_q <= '0;
		end else if (cmd.load && do_append) begin
			acc_q <= acc_new;
			cnt_q <= cnt_new;
		end else if (cmd.emit_data) begin
			cnt_q <= shamt;
		end
	end

	// Hold the raw byte of a mode 2 item
	always_ff @(posedge clk) begin
		if (cmd.load && st.start_raw) begin
			raw_q <= in_code[7:0];
		end
	end

	// Advance the write position, or latch overflow when full
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			ovf_q <= 1'b0;
		end else if (emit_any) begin
			if (full) begin
				ovf_q <= 1'b1;
			end else begin
				wp_q <= wp_q + jbp_pkg::POS_W'(1);
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_any) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_any) begin
			out_byte_q    <= emit_byte;
			out_addr_q    <= wp_q[jbp_pkg::ADDR_W-1:0];
			out_written_q <= !full;
			out_ovf_q     <= ovf_q | full;
			out_last_q    <= cmd.last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {{(jbp_pkg::M_TDATA_W - jbp_pkg::ADDR_W - 10){1'b0}},
		out_ovf_q, out_written_q, out_addr_q, out_byte_q};

	// Checks
	`JBP_ASSERT(a_ovf_sticky, ovf_q |=> ovf_q, "overflow flag cleared")
	`JBP_ASSERT(a_wp_hold, !emit_any |=> $stable(wp_q), "write position moved without a byte")
	`JBP_ASSERT(a_drop_flags, (out_valid_q && !out_written_q) |-> out_ovf_q,
		"dropped byte without overflow")

endmodule

`default_nettype wire

// ----- design/jbp_ctrl.sv -----
// Controller of the JPEG bit packer: sequences load, data, stuffing and
// raw byte emission. Depends on jbp_pkg and the assertion macro header.
`default_nettype none
`include "jpeg_bit_packer_with_stuffing_core_macros.svh"

module jbp_ctrl (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        in_valid,
	output logic                       in_ready,
	input  wire jbp_pkg::jbp_status_t  st,
	output jbp_pkg::jbp_cmd_t          cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EMIT,
		S_STUFF,
		S_RAW
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == S_IDLE);

	// Decode commands and next state
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					if (st.start_raw) begin
						state_d = S_RAW;
					end else if (st.start_bytes) begin
						state_d = S_EMIT;
					end
				end
			end
			S_EMIT: begin
				if (st.out_free) begin
					cmd.emit_data = 1'b1;
					cmd.last      = !st.byte_is_ff && !st.more_after_data;
					if (st.byte_is_ff) begin
						state_d = S_STUFF;
					end else if (!st.more_after_data) begin
						state_d = S_IDLE;
					end
				end
			end
			S_STUFF: begin
				if (st.out_free) begin
					cmd.emit_stuff = 1'b1;
					cmd.last       = !st.more_after_stuff;
					state_d        = st.more_after_stuff ? S_EMIT : S_IDLE;
				end
			end
			S_RAW: begin
				if (st.out_free) begin
					cmd.emit_raw = 1'b1;
					cmd.last     = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Checks
	`JBP_ASSERT(a_one_emit, $onehot0({cmd.emit_data, cmd.emit_stuff, cmd.emit_raw}),
		"more than one byte emitted at once")
	`JBP_ASSERT_NEVER(a_emit_busy, (cmd.emit_data || cmd.emit_stuff || cmd.emit_raw)
		&& !st.out_free, "byte emitted into a busy output register")
	`JBP_ASSERT(a_stuff_after_ff,
		(state_q == S_STUFF) |-> $past(cmd.emit_data || (state_q == S_STUFF)),
		"stuffing without a preceding data byte")

endmodule

`default_nettype wire

// ----- design/jpeg_bit_packer_with_stuffing_core.sv -----
// JPEG entropy bit packer with 0xFF/0x00 stuffing and bounded buffer.
// A word is taken in the idle state; the emit sequencer then moves one output
// byte per cycle into the output register while that register is free, and
// takes no new word until the item is done; an item with no bytes stays idle.
// Reset clears position, accumulator, overflow flag and output valid;
// capacity resets to 2^24.
`default_nettype none

module jpeg_bit_packer_with_stuffing_core (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 s_tvalid,
	output logic                                s_tready,
	// [1:0] mode, [25:2] code, [30:26] bit_count, [31] zero
	input  wire logic [jbp_pkg::S_TDATA_W-1:0]  s_tdata,
	output logic                                m_tvalid,
	input  wire                                 m_tready,
	// [7:0] out_byte, [31:8] byte_address, [32] written, [33] overflow, [39:34] zero
	output logic [jbp_pkg::M_TDATA_W-1:0]       m_tdata,
	output logic                                m_tlast,
	input  wire                                 cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [jbp_pkg::POS_W-1:0]      cfg_data
);

	jbp_pkg::jbp_cmd_t    cmd;
	jbp_pkg::jbp_status_t st;

	jbp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	jbp_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (s_tdata),
		.cmd       (cmd),
		.st        (st),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
// Self-checking testbench for the JPEG bit packer with 0xFF/0x00 byte stuffing.
// Needs jbp_pkg and jpeg_bit_packer_with_stuffing_core; it predicts every output
// word and checks it against the stream that the block sends.
`default_nettype none

module testbench;

	localparam logic [jbp_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 16;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int LONG_HOLD_AFTER = 150;
	localparam int LONG_HOLD_BACKLOG = 10;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic [jbp_pkg::MODE_W-1:0] mode;
		logic [jbp_pkg::CODE_W-1:0] code;
		logic [jbp_pkg::BCNT_W-1:0] bit_count;
	} packer_item_t;

	typedef struct packed {
		logic                       last;
		logic                       overflow;
		logic                       written;
		logic [jbp_pkg::ADDR_W-1:0] address;
		logic [7:0]                 value;
	} out_word_t;

	typedef enum logic [1:0] {
		READY_ALWAYS,
		READY_RANDOM,
		READY_SPARSE
	} ready_style_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [jbp_pkg::S_TDATA_W-1:0] s_tdata = '0;
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [jbp_pkg::M_TDATA_W-1:0] m_tdata;
	logic                          m_tlast;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [jbp_pkg::POS_W-1:0]     cfg_data = '0;

	// Predicted packer state
	logic [31:0]               bit_store = '0;
	int                        bits_held = 0;
	logic [jbp_pkg::POS_W-1:0] buffer_position = '0;
	logic                      overflow_seen = 1'b0;
	logic [jbp_pkg::POS_W-1:0] buffer_capacity = jbp_pkg::CAPACITY_RESET;

	packer_item_t pending_items[$];
	out_word_t    expected_bytes[$];
	packer_item_t offered_item;

	int burst_left = 0;
	int gap_left = 0;
	int failures = 0;
	int results_seen = 0;
	int hold_left = 0;
	bit long_hold_done = 1'b0;
	int segment_left = 0;
	int sparse_phase = 0;
	ready_style_t ready_style = READY_ALWAYS;

	jpeg_bit_packer_with_stuffing_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Store one byte at the current position, or drop it once the buffer is full
	task automatic put_byte(input logic [7:0] value);
		out_word_t word;
		word.value = value;
		word.address = buffer_position[jbp_pkg::ADDR_W-1:0];
		word.last = 1'b0;
		if (buffer_position >= buffer_capacity) begin
			overflow_seen = 1'b1;
			word.written = 1'b0;
		end else begin
			buffer_position = buffer_position + jbp_pkg::POS_W'(1);
			word.written = 1'b1;
		end
		word.overflow = overflow_seen;
		expected_bytes.push_back(word);
	endtask

	// Merge n bits under the held ones and drain whole bytes, MSB first, with stuffing
	task automatic append_bits(input logic [31:0] bits, input int n);
		logic [63:0] merged;
		int          count;
		logic [7:0]  data_byte;
		merged = ({32'd0, bit_store} << n) | ({32'd0, bits} & ((64'd1 << n) - 64'd1));
		count = bits_held + n;
		while (count >= 8) begin
			data_byte = merged[count-8 +: 8];
			put_byte(data_byte);
			if (data_byte == jbp_pkg::BYTE_FF)
				put_byte(jbp_pkg::BYTE_STUFF);
			count = count - 8;
		end
		bits_held = count;
		bit_store = merged[31:0] & ((32'd1 << count) - 32'd1);
	endtask

	// Work out the bytes that one accepted item causes and mark the final one
	task automatic predict_packing(input packer_item_t item);
		int        count_before;
		int        n;
		int        fill;
		logic [7:0] padded;
		out_word_t final_word;
		count_before = expected_bytes.size();
		case (item.mode)
			jbp_pkg::MODE_BITS: begin
				n = (item.bit_count > jbp_pkg::MAX_BITS) ? jbp_pkg::MAX_BITS :
					int'(item.bit_count);
				if (n > 0)
					append_bits({8'd0, item.code}, n);
			end
			jbp_pkg::MODE_FLUSH: begin
				if (bits_held > 0) begin
					fill = 8 - bits_held;
					padded = 8'((bit_store << fill) | ((32'd1 << fill) - 32'd1));
					bit_store = '0;
					bits_held = 0;
					append_bits({24'd0, padded}, 8);
				end
			end
			jbp_pkg::MODE_RAW: put_byte(item.code[7:0]);
			default: ;
		endcase
		if (expected_bytes.size() > count_before) begin
			final_word = expected_bytes.pop_back();
			final_word.last = 1'b1;
			expected_bytes.push_back(final_word);
		end
	endtask

	function automatic packer_item_t make_item(input logic [jbp_pkg::MODE_W-1:0] mode,
			input logic [jbp_pkg::CODE_W-1:0] code,
			input logic [jbp_pkg::BCNT_W-1:0] bit_count);
		packer_item_t item;
		item.mode = mode;
		item.code = code;
		item.bit_count = bit_count;
		return item;
	endfunction

	// Favor bit appends, and codes full of 0xFF lanes so stuffing shows up often
	function automatic packer_item_t random_item();
		packer_item_t item;
		int           pick;
		pick = $urandom_range(0, 99);
		if (pick < 70)
			item.mode = jbp_pkg::MODE_BITS;
		else if (pick < 82)
			item.mode = jbp_pkg::MODE_FLUSH;
		else if (pick < 94)
			item.mode = jbp_pkg::MODE_RAW;
		else
			item.mode = MODE_UNUSED;
		case ($urandom_range(0, 5))
			0: item.code = '1;
			1: item.code = jbp_pkg::CODE_W'($urandom)
				| (jbp_pkg::CODE_W'(8'hFF) << (8 * $urandom_range(0, 2)));
			default: item.code = jbp_pkg::CODE_W'($urandom);
		endcase
		if ($urandom_range(0, 9) == 0)
			item.bit_count = jbp_pkg::BCNT_W'($urandom_range(0, 31));
		else
			item.bit_count = jbp_pkg::BCNT_W'($urandom_range(1, jbp_pkg::MAX_BITS));
		return item;
	endfunction

	task automatic queue_random(input int count);
		repeat (count) pending_items.push_back(random_item());
	endtask

	// Pause the sender until every word has arrived, then let the block settle
	task automatic wait_drained();
		do @(posedge clk);
		while (pending_items.size() != 0 || s_tvalid || expected_bytes.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [jbp_pkg::POS_W-1:0] value);
		@(posedge clk);
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		buffer_capacity = value;
	endtask

	// Driver: offer queued items in bursts with random gaps, predict on acceptance
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				predict_packing(offered_item);
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left = gap_left - 1;
					s_tvalid <= 1'b0;
				end else if (pending_items.size() > 0) begin
					offered_item = pending_items.pop_front();
					s_tdata <= {1'b0, offered_item.bit_count, offered_item.code,
						offered_item.mode};
					s_tvalid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 12);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
					end else begin
						burst_left = burst_left - 1;
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each accepted word against the oldest prediction, pace m_tready
	always @(posedge clk) begin
		out_word_t actual;
		out_word_t predicted;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				actual = {m_tlast, m_tdata[33], m_tdata[32], m_tdata[31:8], m_tdata[7:0]};
				results_seen = results_seen + 1;
				if (expected_bytes.size() == 0) begin
					failures = failures + 1;
					if (failures <= REPORT_LIMIT)
						$display("unexpected word: byte %h addr %0d written %b ovf %b last %b",
							actual.value, actual.address, actual.written, actual.overflow,
							actual.last);
				end else begin
					predicted = expected_bytes.pop_front();
					if (actual.value !== predicted.value
							|| actual.address !== predicted.address
							|| actual.written !== predicted.written
							|| actual.overflow !== predicted.overflow
							|| actual.last !== predicted.last) begin
						failures = failures + 1;
						if (failures <= REPORT_LIMIT)
							$display("mismatch: exp %h @%0d w%b o%b l%b, got %h @%0d w%b o%b l%b",
								predicted.value, predicted.address, predicted.written,
								predicted.overflow, predicted.last, actual.value,
								actual.address, actual.written, actual.overflow, actual.last);
					end
				end
			end
			// Hold off once for a long stretch so the block backs up into its input
			if (hold_left > 0) begin
				hold_left = hold_left - 1;
				m_tready <= 1'b0;
			end else if (!long_hold_done && results_seen >= LONG_HOLD_AFTER
					&& pending_items.size() > LONG_HOLD_BACKLOG) begin
				long_hold_done = 1'b1;
				hold_left = LONG_HOLD_CYCLES;
				m_tready <= 1'b0;
			end else begin
				if (segment_left == 0) begin
					ready_style = ready_style_t'($urandom_range(0, 2));
					segment_left = $urandom_range(10, 60);
				end
				segment_left = segment_left - 1;
				sparse_phase = (sparse_phase + 1) % 4;
				case (ready_style)
					READY_ALWAYS: m_tready <= 1'b1;
					READY_RANDOM: m_tready <= 1'($urandom_range(0, 1));
					default:      m_tready <= (sparse_phase == 0);
				endcase
			end
		end
	end

	// Bound the run
	initial begin
		#2000000;
		$display("== FAIL ==");
		$finish;
	end

	// Reset, then run phases under several buffer capacities
	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Full-size buffer: directed corners first
		write_capacity(jbp_pkg::CAPACITY_RESET);
		pending_items.push_back(make_item(jbp_pkg::MODE_BITS, 24'h000000, 5'd0));
		pending_items.push_back(make_item(jbp_pkg::MODE_FLUSH, 24'h000000, 5'd0));
		pending_items.push_back(make_item(MODE_UNUSED, 24'hFFFFFF, 5'd31));
		pending_items.push_back(make_item(jbp_pkg::MODE_BITS, 24'hFFFFFF, 5'd24));
		pending_items.push_back(make_item(jbp_pkg::MODE_BITS, 24'h000000, 5'd31));
		pending_items.push_back(make_item(jbp_pkg::MODE_BITS, 24'h000001, 5'd1));
		pending_items.push_back(make_item(jbp_pkg::MODE_FLUSH, 24'hFFFFFF, 5'd31));
		pending_items.push_back(make_item(jbp_pkg::MODE_BITS, 24'h000005, 5'd3));
		pending_items.push_back(make_item(jbp_pkg::MODE_BITS, 24'hFFFFFF, 5'd20));
		pending_items.push_back(make_item(jbp_pkg::MODE_FLUSH, 24'h000000, 5'd0));
		pending_items.push_back(make_item(jbp_pkg::MODE_RAW, 24'h0000FF, 5'd0));
		pending_items.push_back(make_item(jbp_pkg::MODE_RAW, 24'hABCD00, 5'd31));
		pending_items.push_back(make_item(jbp_pkg::MODE_BITS, 24'h00007F, 5'd7));
		pending_items.push_back(make_item(jbp_pkg::MODE_RAW, 24'h00005A, 5'd7));
		pending_items.push_back(make_item(jbp_pkg::MODE_BITS, 24'h000001, 5'd1));
		pending_items.push_back(make_item(jbp_pkg::MODE_BITS, 24'h800000, 5'd24));
		pending_items.push_back(make_item(jbp_pkg::MODE_BITS, 24'hAAAAAA, 5'd16));
		pending_items.push_back(make_item(jbp_pkg::MODE_FLUSH, 24'h000000, 5'd0));
		pending_items.push_back(make_item(jbp_pkg::MODE_BITS, 24'hFFFFFF, 5'd25));
		pending_items.push_back(make_item(jbp_pkg::MODE_BITS, 24'h000003, 5'd2));
		pending_items.push_back(make_item(jbp_pkg::MODE_FLUSH, 24'h000000, 5'd0));
		pending_items.push_back(make_item(MODE_UNUSED, 24'h123456, 5'd5));
		pending_items.push_back(make_item(jbp_pkg::MODE_BITS, 24'h7FFFFF, 5'd23));
		wait_drained();
		queue_random(90);
		wait_drained();

		// Tight buffer: fills part way through, then drops and latches overflow
		write_capacity(buffer_position + jbp_pkg::POS_W'(40));
		queue_random(60);
		wait_drained();

		// Empty buffer: every byte dropped
		write_capacity('0);
		queue_random(30);
		wait_drained();

		// Largest capacity the register holds
		write_capacity('1);
		queue_random(70);
		wait_drained();

		// Room for exactly one more byte
		write_capacity(buffer_position + jbp_pkg::POS_W'(1));
		queue_random(20);
		wait_drained();

		write_capacity(buffer_position + jbp_pkg::POS_W'(10000));
		queue_random(50);
		wait_drained();

		if (failures == 0 && expected_bytes.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

`default_nettype wire
